/* design/stcm_pkg.sv */
`default_nettype none

package stcm_pkg;

   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int COLOR_WIDTH     = 8;
   localparam int COLOR_SAT_WIDTH = COLOR_WIDTH + 1;
   localparam logic [COLOR_WIDTH-1:0] COLOR_MAX = {COLOR_WIDTH{1'b1}};

   localparam logic [CSR_DATA_WIDTH-1:0] RANGE_LOW_RESET  = CSR_DATA_WIDTH'(0);
   localparam logic [CSR_DATA_WIDTH-1:0] RANGE_HIGH_RESET = CSR_DATA_WIDTH'(65536);

   // t is an unsigned fraction, one equals 2**T_BITS
   localparam int T_BITS  = 16;
   localparam int T_WIDTH = T_BITS + 1;
   localparam logic [T_WIDTH-1:0] T_ONE  = T_WIDTH'(2 ** T_BITS);
   localparam logic [T_WIDTH-1:0] T_HALF = T_WIDTH'(2 ** (T_BITS - 1));

   localparam logic [T_WIDTH-1:0] JET_A = T_WIDTH'(2 ** T_BITS / 8);
   localparam logic [T_WIDTH-1:0] JET_B = T_WIDTH'(3 * 2 ** T_BITS / 8);
   localparam logic [T_WIDTH-1:0] JET_C = T_WIDTH'(5 * 2 ** T_BITS / 8);
   localparam logic [T_WIDTH-1:0] JET_D = T_WIDTH'(7 * 2 ** T_BITS / 8);
   localparam logic [T_WIDTH-1:0] HOT_A = T_WIDTH'(21823);
   localparam logic [T_WIDTH-1:0] HOT_B = T_WIDTH'(43713);

   // ramp: (v * 255 + half) >> T_BITS
   // hot:  floor((x * 10625 + 454656) / (2**13 * 111)), the 1/111 by reciprocal
   localparam int COEF_WIDTH  = 14;
   localparam logic [COEF_WIDTH-1:0] RAMP_MUL = COEF_WIDTH'(255);
   localparam logic [COEF_WIDTH-1:0] HOT_MUL  = COEF_WIDTH'(10625);
   localparam int PROD_WIDTH  = T_WIDTH + COEF_WIDTH;
   localparam logic [PROD_WIDTH-1:0] RAMP_ROUND = PROD_WIDTH'(2 ** (T_BITS - 1));
   localparam logic [PROD_WIDTH-1:0] HOT_BIAS   = PROD_WIDTH'(454656);
   localparam int HOT_PRE_SHIFT = 13;
   localparam int HOT_M_WIDTH   = 15;
   localparam int HOT_DIV       = 111;
   localparam int HOT_SHIFT     = 24;
   localparam int MAGIC_WIDTH   = 18;
   localparam logic [MAGIC_WIDTH-1:0] HOT_MAGIC =
      MAGIC_WIDTH'((2 ** HOT_SHIFT + HOT_DIV - 1) / HOT_DIV);
   localparam int HOT_P_WIDTH   = HOT_M_WIDTH + MAGIC_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_RANGE_LOW  = 2'd0,
      REG_RANGE_HIGH = 2'd1,
      REG_MAP_SELECT = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      MAP_JET  = 2'd0,
      MAP_HOT  = 2'd1,
      MAP_GRAY = 2'd2
   } map_sel_type;

   typedef enum logic [1:0] {
      CLS_DIV   = 2'd0,
      CLS_ZERO  = 2'd1,
      CLS_ONE   = 2'd2,
      CLS_BLACK = 2'd3
   } range_cls_type;

   typedef enum logic [1:0] {
      CH_ZERO = 2'd0,
      CH_FULL = 2'd1,
      CH_RAMP = 2'd2,
      CH_HOT  = 2'd3
   } chan_kind_type;

   typedef struct packed {
      chan_kind_type       kind;
      logic [T_WIDTH-1:0]  arg;
   } chan_op_type;

endpackage

`default_nettype wire

/* design/stcm_ifs.sv */
`default_nettype none

interface stcm_req_if #(
   parameter int SAMPLE_WIDTH = 32
) ();
   logic                            valid;
   logic                            ready;
   logic signed [SAMPLE_WIDTH-1:0]  sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface stcm_rsp_if ();
   import stcm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [COLOR_WIDTH-1:0]  red;
   logic [COLOR_WIDTH-1:0]  green;
   logic [COLOR_WIDTH-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface stcm_csr_if ();
   import stcm_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CSR_INDEX_WIDTH-1:0]  index;
   logic [CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/scalar_to_rgb_colormap.sv */
// scalar_to_rgb_colormap
// Colours a stream of signed fixed-point samples with the jet, hot or grayscale map.
// req_chan carries one sample per word, rsp_chan one red/green/blue word back for
// every sample, in order. csr_chan writes range_low (index 0), range_high (index 1)
// and map_select (index 2); it is always ready. The user must write it only while no
// word is in flight; the block does not enforce this. A range of zero or less gives black.
// A result word passes through 23 register stages: input, range compare, 16
// restoring divide stages (one quotient bit each, these set the depth), channel
// select, multiply, rounding, second multiply and the output register.
// Throughput: one word per cycle while rsp_chan is ready.
// Reset clears all stage valid bits and sets range_low 0, range_high 65536, jet.
// When rsp_chan stalls, the output word holds and the pipeline keeps filling its
// empty stages; req_chan ready falls only once every stage holds a word.
`default_nettype none

module scalar_to_rgb_colormap #(
   parameter int SAMPLE_WIDTH = 32
) (
   input wire           clock,
   input wire           reset,
   stcm_req_if.sink     req_chan,
   stcm_rsp_if.source   rsp_chan,
   stcm_csr_if.sink     csr_chan
);
   import stcm_pkg::*;

   localparam int ST_IN   = 0;
   localparam int ST_CLS  = 1;
   localparam int ST_KIND = ST_CLS + T_BITS + 1;
   localparam int ST_MUL  = ST_KIND + 1;
   localparam int ST_POST = ST_MUL + 1;
   localparam int ST_MUL2 = ST_POST + 1;
   localparam int ST_OUT  = ST_MUL2 + 1;
   localparam int NUM_ST  = ST_OUT + 1;

   // configuration

   logic [CSR_DATA_WIDTH-1:0]        range_low_ff;
   logic [CSR_DATA_WIDTH-1:0]        range_high_ff;
   map_sel_type                      map_select_ff;
   logic signed [SAMPLE_WIDTH-1:0]   lo_w;
   logic signed [SAMPLE_WIDTH-1:0]   hi_w;
   logic signed [SAMPLE_WIDTH:0]     d_in;
   logic signed [SAMPLE_WIDTH:0]     d_ff;
   logic [SAMPLE_WIDTH-1:0]          div_w;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
         map_select_ff <= MAP_JET;
      end else if (csr_chan.valid) begin
         case (csr_reg_type'(csr_chan.index))
            REG_RANGE_LOW:  range_low_ff  <= csr_chan.data;
            REG_RANGE_HIGH: range_high_ff <= csr_chan.data;
            REG_MAP_SELECT: map_select_ff <= map_sel_type'(csr_chan.data[1:0]);
            default: ;
         endcase
      end
   end

   if (SAMPLE_WIDTH <= CSR_DATA_WIDTH) begin : g_narrow
      assign lo_w = range_low_ff[SAMPLE_WIDTH-1:0];
      assign hi_w = range_high_ff[SAMPLE_WIDTH-1:0];
   end else begin : g_wide
      assign lo_w = {{(SAMPLE_WIDTH - CSR_DATA_WIDTH){1'b0}}, range_low_ff};
      assign hi_w = {{(SAMPLE_WIDTH - CSR_DATA_WIDTH){1'b0}}, range_high_ff};
   end

   assign d_in  = {hi_w[SAMPLE_WIDTH-1], hi_w} - {lo_w[SAMPLE_WIDTH-1], lo_w};
   assign div_w = d_ff[SAMPLE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   // stage valid bits and advance

   logic [NUM_ST-1:0] v_ff;
   logic [NUM_ST-1:0] v_in;
   logic [NUM_ST-1:0] en;

   for (genvar k = 0; k < NUM_ST; k++) begin : g_en
      assign en[k] = rsp_chan.ready || !(&v_ff[ST_OUT:k]);
   end

   always_comb begin
      for (int k = 0; k < NUM_ST; k++) begin
         if (!en[k]) begin
            v_in[k] = v_ff[k];
         end else if (k == ST_IN) begin
            v_in[k] = req_chan.valid;
         end else begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = en[ST_IN];
   assign rsp_chan.valid = v_ff[ST_OUT];

   // input and range compare

   logic signed [SAMPLE_WIDTH-1:0]  sample_ff;
   logic signed [SAMPLE_WIDTH:0]    num_in;
   logic                            above_in;
   range_cls_type                   cls_in;
   range_cls_type                   cls_ff [T_BITS+1];
   logic [SAMPLE_WIDTH-1:0]         rem_ff [T_BITS];
   logic [T_BITS-1:0]               q_ff [T_BITS];

   always_ff @(posedge clock) begin
      if (en[ST_IN]) begin
         sample_ff <= req_chan.sample;
      end
   end

   assign num_in   = {sample_ff[SAMPLE_WIDTH-1], sample_ff} - {lo_w[SAMPLE_WIDTH-1], lo_w};
   assign above_in = (sample_ff >= hi_w);

   always_comb begin
      if (d_ff[SAMPLE_WIDTH] || d_ff == '0) begin
         cls_in = CLS_BLACK;
      end else if (num_in[SAMPLE_WIDTH] || num_in == '0) begin
         cls_in = CLS_ZERO;
      end else if (above_in) begin
         cls_in = CLS_ONE;
      end else begin
         cls_in = CLS_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_CLS]) begin
         cls_ff[0] <= cls_in;
         rem_ff[0] <= num_in[SAMPLE_WIDTH-1:0];
      end
   end

   // restoring divide, one quotient bit per stage

   for (genvar k = 0; k < T_BITS; k++) begin : g_div
      logic [SAMPLE_WIDTH:0]  shifted;
      logic [SAMPLE_WIDTH:0]  trial;
      logic [T_BITS-1:0]      q_prev;
      logic                   take;

      assign shifted = {rem_ff[k], 1'b0};
      assign trial   = shifted - {1'b0, div_w};
      assign take    = !trial[SAMPLE_WIDTH];

      if (k == 0) begin : g_first
         assign q_prev = '0;
      end else begin : g_next
         assign q_prev = q_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en[ST_CLS + k + 1]) begin
            q_ff[k]     <= {q_prev[T_BITS-2:0], take};
            cls_ff[k+1] <= cls_ff[k];
         end
      end

      if (k < T_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[ST_CLS + k + 1]) begin
               rem_ff[k+1] <= take ? trial[SAMPLE_WIDTH-1:0] : shifted[SAMPLE_WIDTH-1:0];
            end
         end
      end
   end

   // channel select

   logic [T_WIDTH-1:0]  t_w;
   chan_op_type         op_in [3];
   chan_op_type         op_ff [3];

   always_comb begin
      case (cls_ff[T_BITS])
         CLS_ONE: t_w = T_ONE;
         CLS_DIV: t_w = {1'b0, q_ff[T_BITS-1]};
         default: t_w = '0;
      endcase
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         op_in[c] = '{kind: CH_ZERO, arg: '0};
      end
      if (cls_ff[T_BITS] != CLS_BLACK) begin
         case (map_select_ff)
            MAP_JET: begin
               if (t_w < JET_A) begin
                  op_in[2] = '{kind: CH_RAMP, arg: T_WIDTH'(T_HALF + (t_w << 2))};
               end else if (t_w < JET_B) begin
                  op_in[1] = '{kind: CH_RAMP, arg: T_WIDTH'((t_w - JET_A) << 2)};
                  op_in[2] = '{kind: CH_FULL, arg: '0};
               end else if (t_w < JET_C) begin
                  op_in[0] = '{kind: CH_RAMP, arg: T_WIDTH'((t_w - JET_B) << 2)};
                  op_in[1] = '{kind: CH_FULL, arg: '0};
                  op_in[2] = '{kind: CH_RAMP, arg: T_WIDTH'(T_ONE - ((t_w - JET_B) << 2))};
               end else if (t_w < JET_D) begin
                  op_in[0] = '{kind: CH_FULL, arg: '0};
                  op_in[1] = '{kind: CH_RAMP, arg: T_WIDTH'(T_ONE - ((t_w - JET_C) << 2))};
               end else begin
                  op_in[0] = '{kind: CH_RAMP, arg: T_WIDTH'(T_ONE - ((t_w - JET_D) << 2))};
               end
            end
            MAP_HOT: begin
               if (t_w < HOT_A) begin
                  op_in[0] = '{kind: CH_HOT, arg: t_w};
               end else if (t_w < HOT_B) begin
                  op_in[0] = '{kind: CH_FULL, arg: '0};
                  op_in[1] = '{kind: CH_HOT, arg: T_WIDTH'(t_w - HOT_A)};
               end else begin
                  op_in[0] = '{kind: CH_FULL, arg: '0};
                  op_in[1] = '{kind: CH_FULL, arg: '0};
                  op_in[2] = '{kind: CH_HOT, arg: T_WIDTH'(t_w - HOT_B)};
               end
            end
            default: begin
               for (int c = 0; c < 3; c++) begin
                  op_in[c] = '{kind: CH_RAMP, arg: t_w};
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_KIND]) begin
         op_ff <= op_in;
      end
   end

   // scale, round, saturate

   logic [PROD_WIDTH-1:0]       prod_in [3];
   logic [PROD_WIDTH-1:0]       prod_ff [3];
   chan_kind_type               mk_ff [3];
   logic [PROD_WIDTH-1:0]       ramp_sum [3];
   logic [PROD_WIDTH-1:0]       hot_sum [3];
   logic [COLOR_SAT_WIDTH-1:0]  ramp_c [3];
   logic [COLOR_WIDTH-1:0]      rc_in [3];
   logic [COLOR_WIDTH-1:0]      rc_ff [3];
   logic [COLOR_WIDTH-1:0]      rc2_ff [3];
   logic [HOT_M_WIDTH-1:0]      hm_in [3];
   logic [HOT_M_WIDTH-1:0]      hm_ff [3];
   chan_kind_type               pk_ff [3];
   logic [HOT_P_WIDTH-1:0]      hp_in [3];
   logic [HOT_P_WIDTH-1:0]      hp_ff [3];
   chan_kind_type               qk_ff [3];
   logic [COLOR_SAT_WIDTH-1:0]  hot_c [3];
   logic [COLOR_WIDTH-1:0]      color_in [3];
   logic [COLOR_WIDTH-1:0]      color_ff [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      assign prod_in[c] = PROD_WIDTH'(op_ff[c].arg)
                        * PROD_WIDTH'((op_ff[c].kind == CH_HOT) ? HOT_MUL : RAMP_MUL);

      assign ramp_sum[c] = prod_ff[c] + RAMP_ROUND;
      assign hot_sum[c]  = prod_ff[c] + HOT_BIAS;
      assign ramp_c[c]   = ramp_sum[c][T_BITS +: COLOR_SAT_WIDTH];
      assign rc_in[c]    = ramp_c[c][COLOR_WIDTH] ? COLOR_MAX : ramp_c[c][COLOR_WIDTH-1:0];
      assign hm_in[c]    = hot_sum[c][HOT_PRE_SHIFT +: HOT_M_WIDTH];

      assign hp_in[c]    = HOT_P_WIDTH'(hm_ff[c]) * HOT_P_WIDTH'(HOT_MAGIC);

      assign hot_c[c]    = hp_ff[c][HOT_SHIFT +: COLOR_SAT_WIDTH];

      always_comb begin
         case (qk_ff[c])
            CH_FULL: color_in[c] = COLOR_MAX;
            CH_RAMP: color_in[c] = rc2_ff[c];
            CH_HOT:  color_in[c] = hot_c[c][COLOR_WIDTH] ? COLOR_MAX
                                                          : hot_c[c][COLOR_WIDTH-1:0];
            default: color_in[c] = '0;
         endcase
      end

      always_ff @(posedge clock) begin
         if (en[ST_MUL]) begin
            prod_ff[c] <= prod_in[c];
            mk_ff[c]   <= op_ff[c].kind;
         end
         if (en[ST_POST]) begin
            rc_ff[c] <= rc_in[c];
            hm_ff[c] <= hm_in[c];
            pk_ff[c] <= mk_ff[c];
         end
         if (en[ST_MUL2]) begin
            hp_ff[c]  <= hp_in[c];
            rc2_ff[c] <= rc_ff[c];
            qk_ff[c]  <= pk_ff[c];
         end
         if (en[ST_OUT]) begin
            color_ff[c] <= color_in[c];
         end
      end
   end

   assign rsp_chan.red   = color_ff[0];
   assign rsp_chan.green = color_ff[1];
   assign rsp_chan.blue  = color_ff[2];

   // checks

   logic in_take;
   logic out_take;

   assign in_take  = req_chan.valid && en[ST_IN];
   assign out_take = v_ff[ST_OUT] && rsp_chan.ready;

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         $countones(v_ff) == $past($countones(v_ff)) + int'($past(in_take))
                                                     - int'($past(out_take)))
      else $error("pipeline word count broken");

   a_full_red: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(en[ST_OUT] && v_ff[ST_MUL2] && qk_ff[0] == CH_FULL))
         |-> color_ff[0] == COLOR_MAX)
      else $error("saturated red channel not full scale");

   a_zero_blue: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(en[ST_OUT] && v_ff[ST_MUL2] && qk_ff[2] == CH_ZERO))
         |-> color_ff[2] == '0)
      else $error("dark blue channel not zero");

endmodule

`default_nettype wire
